@@ hw/rtl/lcr_pkg.sv @@
// Shared types and constants for the load-cell converter serial reader.
// No dependencies.
package lcr_pkg;

  localparam int unsigned SampleBitsDef = 24;
  localparam int unsigned MaxAverageDef = 255;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_READ  = 3'd1,
    OP_TARE  = 3'd2,
    OP_PDOWN = 3'd3,
    OP_PUP   = 3'd4
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN    = 3'd0,
    CFG_HALF    = 3'd1,
    CFG_TIMEOUT = 3'd2,
    CFG_SETTLE  = 3'd3,
    CFG_PDOWN   = 3'd4,
    CFG_SCALE   = 3'd5
  } cfg_e;

  // serial line phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WAIT   = 3'd1,
    PH_HIGH   = 3'd2,
    PH_LOW    = 3'd3,
    PH_PDOWN  = 3'd4,
    PH_SETTLE = 3'd5
  } phase_e;

  // sequencing of the item handshake and the result arithmetic
  typedef enum logic [2:0] {
    CT_IDLE = 3'd0,
    CT_DIV  = 3'd1,
    CT_NET  = 3'd2,
    CT_MUL  = 3'd3,
    CT_FIN  = 3'd4
  } ctl_e;

  typedef struct packed {
    logic tick;
    logic div_step;
    logic calc_net;
    logic calc_mul;
    logic finish;
  } lcr_cmd_t;

  typedef struct packed {
    logic need_arith;
    logic div_last;
  } lcr_stat_t;

endpackage

@@ hw/rtl/lcr_ctrl.sv @@
// Controller for the load-cell reader: handshakes and arithmetic sequencing.
// Depends on lcr_pkg.
module lcr_ctrl import lcr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  lcr_stat_t stat_i,
  output lcr_cmd_t  cmd_o
);

  ctl_e state_q, state_d;
  logic ov_q, ov_d;
  logic accept;

  assign in_stall_o  = (state_q != CT_IDLE) || (ov_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CT_IDLE: if (accept && stat_i.need_arith) state_d = CT_DIV;
      CT_DIV:  if (stat_i.div_last) state_d = CT_NET;
      CT_NET:  state_d = CT_MUL;
      CT_MUL:  state_d = CT_FIN;
      CT_FIN:  state_d = CT_IDLE;
      default: state_d = CT_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.tick     = accept;
    cmd_o.div_step = (state_q == CT_DIV);
    cmd_o.calc_net = (state_q == CT_NET);
    cmd_o.calc_mul = (state_q == CT_MUL);
    cmd_o.finish   = (state_q == CT_FIN);
  end

  always_comb begin
    ov_d = ov_q && out_stall_i;
    if ((accept && !stat_i.need_arith) || (state_q == CT_FIN)) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CT_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

endmodule

@@ hw/rtl/lcr_dp.sv @@
// Datapath for the load-cell reader: serial line timing, sample sum, divider,
// scaling multiplier, config registers and result register. Depends on lcr_pkg.
module lcr_dp import lcr_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  parameter int unsigned MAX_AVERAGE = MaxAverageDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [2:0]          operation_i,
  input  logic [7:0]          sample_count_i,
  input  logic                dout_level_i,
  input  lcr_cmd_t            cmd_i,
  output lcr_stat_t           stat_o,
  output logic                sck_level_o,
  output logic                busy_res_o,
  output logic                done_res_o,
  output logic signed [23:0]  raw_average_o,
  output logic signed [24:0]  net_counts_o,
  output logic signed [39:0]  units_o,
  output logic                timed_out_o
);

  localparam int unsigned SUM_W  = SAMPLE_BITS + 8;
  localparam int unsigned QW     = SUM_W + 1;
  localparam int unsigned BIT_W  = $clog2(SAMPLE_BITS + 4);
  localparam int unsigned DCNT_W = $clog2(SUM_W);
  localparam logic signed [QW-1:0] AVG_HI = QW'(8388607);
  localparam logic signed [QW-1:0] AVG_LO = -AVG_HI - QW'(1);
  localparam logic signed [40:0] U_HI = 41'sh07FFFFFFFFF;
  localparam logic signed [40:0] U_LO = -U_HI - 41'sd1;

  // configuration
  logic [1:0]         gain_q;
  logic [7:0]         half_q;
  logic [31:0]        tmo_q, settle_q;
  logic [15:0]        pdn_q;
  logic signed [31:0] recip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= 2'd1;
      half_q   <= 8'd100;
      tmo_q    <= 32'd50000000;
      settle_q <= 32'd10000000;
      pdn_q    <= 16'd6500;
      recip_q  <= 32'sd16777216;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_GAIN:    gain_q   <= cfg_data_i[1:0];
        CFG_HALF:    half_q   <= cfg_data_i[7:0];
        CFG_TIMEOUT: tmo_q    <= cfg_data_i;
        CFG_SETTLE:  settle_q <= cfg_data_i;
        CFG_PDOWN:   pdn_q    <= cfg_data_i[15:0];
        CFG_SCALE:   recip_q  <= $signed(cfg_data_i);
        default:     ;
      endcase
    end
  end

  // line state
  phase_e                   ph_q, ph_d;
  logic [31:0]              tc_q, tc_d;
  logic [BIT_W-1:0]         bi_q, bi_d;
  logic [SAMPLE_BITS-1:0]   sw_q, sw_d;
  logic [7:0]               left_q, left_d, tot_q, tot_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  op_e                      kind_q, kind_d;
  logic                     clk_q, clk_d, tos_q, tos_d;
  logic                     done, final_s, sample_end;
  logic [7:0]               half_eff, cnt;
  logic signed [SUM_W-1:0]  sext;

  assign half_eff = (half_q == 8'd0) ? 8'd1 : half_q;

  always_comb begin
    ph_d = ph_q; tc_d = tc_q; bi_d = bi_q; sw_d = sw_q;
    left_d = left_q; tot_d = tot_q; sum_d = sum_q; kind_d = kind_q;
    clk_d = clk_q; tos_d = tos_q;
    done = 1'b0; final_s = 1'b0; sample_end = 1'b0;
    cnt = sample_count_i;
    sext = '0;
    if (cmd_i.tick) begin
      unique case (ph_q)
        PH_IDLE: begin
          if (operation_i == OP_READ || operation_i == OP_TARE) begin
            if (cnt == 8'd0) cnt = 8'd1;
            if (cnt > 8'(MAX_AVERAGE)) cnt = 8'(MAX_AVERAGE);
            kind_d = op_e'(operation_i);
            tot_d = cnt; left_d = cnt; sum_d = '0; tos_d = 1'b0;
            ph_d = PH_WAIT; tc_d = '0; clk_d = 1'b0;
          end else if (operation_i == OP_PDOWN) begin
            kind_d = OP_PDOWN; clk_d = 1'b1; tc_d = '0; ph_d = PH_PDOWN;
          end else if (operation_i == OP_PUP) begin
            kind_d = OP_PUP; clk_d = 1'b0; tc_d = '0; ph_d = PH_SETTLE;
          end
        end
        PH_WAIT: begin
          if (!dout_level_i) begin
            ph_d = PH_HIGH; clk_d = 1'b1; tc_d = 32'd1; bi_d = '0; sw_d = '0;
          end else if (tc_q >= tmo_q) begin
            tos_d = 1'b1; sw_d = '0; sample_end = 1'b1;
          end else begin
            tc_d = tc_q + 32'd1;
          end
        end
        PH_HIGH: begin
          if (tc_q >= {24'd0, half_eff}) begin
            if (bi_q < BIT_W'(SAMPLE_BITS)) sw_d = {sw_q[SAMPLE_BITS-2:0], dout_level_i};
            bi_d = bi_q + BIT_W'(1);
            ph_d = PH_LOW; clk_d = 1'b0; tc_d = 32'd1;
          end else begin
            tc_d = tc_q + 32'd1;
          end
        end
        PH_LOW: begin
          if (tc_q >= {24'd0, half_eff}) begin
            if (bi_q < BIT_W'(SAMPLE_BITS) + BIT_W'(gain_q)) begin
              ph_d = PH_HIGH; clk_d = 1'b1; tc_d = 32'd1;
            end else begin
              sample_end = 1'b1;
            end
          end else begin
            tc_d = tc_q + 32'd1;
          end
        end
        PH_PDOWN: begin
          if (tc_q >= {16'd0, pdn_q}) begin
            ph_d = PH_IDLE; done = 1'b1;
          end else begin
            tc_d = tc_q + 32'd1;
          end
        end
        PH_SETTLE: begin
          if (tc_q >= settle_q) begin
            tot_d = 8'd1; left_d = 8'd1; sum_d = '0; tos_d = 1'b0;
            ph_d = PH_WAIT; tc_d = '0; clk_d = 1'b0;
          end else begin
            tc_d = tc_q + 32'd1;
          end
        end
        default: ph_d = PH_IDLE;
      endcase
      if (sample_end) begin
        sext = SUM_W'($signed(sw_d));
        sum_d = sum_q + sext;
        if (left_q != 8'd0) left_d = left_q - 8'd1;
        clk_d = 1'b0; tc_d = '0;
        if (left_d != 8'd0) begin
          ph_d = PH_WAIT;
        end else begin
          ph_d = PH_IDLE; done = 1'b1; final_s = 1'b1;
        end
      end
    end
  end

  assign stat_o.need_arith = final_s && (kind_q == OP_READ || kind_q == OP_TARE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; tc_q <= '0; bi_q <= '0; sw_q <= '0;
      left_q <= '0; tot_q <= '0; sum_q <= '0; kind_q <= OP_NONE;
      clk_q <= 1'b0; tos_q <= 1'b0;
    end else begin
      ph_q <= ph_d; tc_q <= tc_d; bi_q <= bi_d; sw_q <= sw_d;
      left_q <= left_d; tot_q <= tot_d; sum_q <= sum_d; kind_q <= kind_d;
      clk_q <= clk_d; tos_q <= tos_d;
    end
  end

  // restoring divider on the magnitude, one quotient bit a cycle
  logic [SUM_W-1:0]  dq_q;
  logic [7:0]        rem_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic              neg_q;
  logic [8:0]        trial;
  logic              qbit;

  assign trial = {rem_q, dq_q[SUM_W-1]};
  assign qbit  = (trial >= {1'b0, tot_q});
  assign stat_o.div_last = (dcnt_q == DCNT_W'(SUM_W - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick && stat_o.need_arith) begin
      neg_q  <= sum_d[SUM_W-1];
      dq_q   <= sum_d[SUM_W-1] ? SUM_W'(-sum_d) : SUM_W'(sum_d);
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= qbit ? 8'(trial - {1'b0, tot_q}) : trial[7:0];
      dq_q   <= {dq_q[SUM_W-2:0], qbit};
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
  end

  // average, net and scaling
  logic signed [QW-1:0] quo;
  logic signed [23:0]   avg_c, avg_q, tare_q;
  logic signed [24:0]   net_q;
  logic signed [56:0]   prod_q;
  logic signed [40:0]   ush;
  logic signed [39:0]   units_c;

  assign quo = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});

  always_comb begin
    if (quo > AVG_HI)      avg_c = 24'sh7FFFFF;
    else if (quo < AVG_LO) avg_c = 24'sh800000;
    else                   avg_c = quo[23:0];
  end

  assign ush = prod_q[56:16];

  always_comb begin
    if (ush > U_HI)      units_c = 40'sh7FFFFFFFFF;
    else if (ush < U_LO) units_c = 40'sh8000000000;
    else                 units_c = ush[39:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tare_q <= '0;
    end else if (cmd_i.calc_net && kind_q == OP_TARE) begin
      tare_q <= avg_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_net) begin
      avg_q <= avg_c;
      net_q <= {avg_c[23], avg_c} - {tare_q[23], tare_q};
    end
    if (cmd_i.calc_mul) prod_q <= 57'(net_q) * 57'(recip_q);
  end

  // result register; the timeout flag belongs to the conversions that end here
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick && !stat_o.need_arith) begin
      sck_level_o   <= clk_d;
      busy_res_o    <= (ph_d != PH_IDLE);
      done_res_o    <= done;
      raw_average_o <= '0;
      net_counts_o  <= '0;
      units_o       <= '0;
      timed_out_o   <= final_s && tos_d;
    end else if (cmd_i.finish) begin
      sck_level_o   <= 1'b0;
      busy_res_o    <= 1'b0;
      done_res_o    <= 1'b1;
      raw_average_o <= avg_q;
      net_counts_o  <= (kind_q == OP_READ) ? net_q : 25'sd0;
      units_o       <= (kind_q == OP_READ) ? units_c : 40'sd0;
      timed_out_o   <= tos_q;
    end
  end

endmodule

@@ hw/rtl/load_cell_adc_serial_reader.sv @@
// Top level of the load-cell converter serial reader.
// Depends on lcr_pkg, lcr_ctrl and lcr_dp.
//
// Each input item is one timing tick: the sampled converter data pin plus an
// optional command (read, tare, power down, power up) with a sample count.
// Every accepted item gives exactly one result item: the serial clock level
// for this tick, busy and done flags and, on the completing tick, the
// average, net counts, scaled units and a timeout flag.
// Plain ticks: the item is taken, its result is registered the next cycle,
// and one item per cycle is sustained while the result side keeps up.
// Completing tick of a read or tare: the sum is divided one quotient bit per
// cycle, then the average and net are formed, the scaling multiplier runs and
// the result is loaded, all before the next item is taken. A new item is taken
// while the result register is empty or is being taken. When the receiver
// stalls, the result holds and input stalls behind it. Reset puts the line in
// idle with the clock low, clears the tare offset and loads the default
// configuration. The user must write configuration only while idle; the block
// itself does not enforce it.
module load_cell_adc_serial_reader import lcr_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  parameter int unsigned MAX_AVERAGE = MaxAverageDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          operation_i,
  input  logic [7:0]          sample_count_i,
  input  logic                dout_level_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                sck_level_o,
  output logic                busy_res_o,
  output logic                done_res_o,
  output logic signed [23:0]  raw_average_o,
  output logic signed [24:0]  net_counts_o,
  output logic signed [39:0]  units_o,
  output logic                timed_out_o
);

  lcr_cmd_t  cmd;
  lcr_stat_t stat;

  lcr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  lcr_dp #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_AVERAGE(MAX_AVERAGE)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .operation_i, .sample_count_i, .dout_level_i,
    .cmd_i(cmd), .stat_o(stat),
    .sck_level_o, .busy_res_o, .done_res_o, .raw_average_o,
    .net_counts_o, .units_o, .timed_out_o
  );

endmodule

@@ hw/rtl/lcr_checker.sv @@
// Port-level checks for the load-cell reader, bound to the top level.
// Depends on lcr_pkg.
module lcr_checker import lcr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               busy_res_o,
  input logic               done_res_o,
  input logic signed [23:0] raw_average_o,
  input logic signed [24:0] net_counts_o,
  input logic signed [39:0] units_o,
  input logic               timed_out_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("item taken while result blocked");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done while busy");

  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> raw_average_o == 24'sd0 &&
      net_counts_o == 25'sd0 && units_o == 40'sd0 && !timed_out_o)
    else $error("result fields set without done");

endmodule

bind load_cell_adc_serial_reader lcr_checker u_lcr_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .busy_res_o,
  .done_res_o, .raw_average_o, .net_counts_o, .units_o, .timed_out_o
);

@@ tb/tb_load_cell_adc_serial_reader.sv @@
// Self-checking testbench for load_cell_adc_serial_reader: one tick per item, a
// line-level predictor of the converter readout, random idling on both sides.
// Depends on lcr_pkg and the RTL of the block only.
module tb_load_cell_adc_serial_reader;
  import lcr_pkg::*;

  typedef struct packed {
    logic               sck;
    logic               busy;
    logic               done;
    logic signed [23:0] avg;
    logic signed [24:0] net;
    logic signed [39:0] units;
    logic               tout;
  } reading_t;

  // bit patterns driven on the data pin during a conversion
  typedef enum int {
    PAT_RANDOM, PAT_ONES, PAT_ZEROS, PAT_NEVER_READY, PAT_MIN, PAT_MAX
  } pattern_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_GAIN;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         operation_i = OP_NONE;
  logic [7:0]         sample_count_i = '0;
  logic               dout_level_i = 1'b1;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               sck_level_o, busy_res_o, done_res_o, timed_out_o;
  logic signed [23:0] raw_average_o;
  logic signed [24:0] net_counts_o;
  logic signed [39:0] units_o;

  load_cell_adc_serial_reader DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copy of the registers and line state
  int unsigned c_gain = 1, c_half = 100, c_timeout = 50000000, c_settle = 10000000;
  int unsigned c_pdown = 6500;
  longint      c_scale = 16777216;

  phase_e      ln_phase = PH_IDLE;
  int unsigned ln_ticks = 0, ln_bit = 0, ln_left = 0, ln_total = 0, ln_kind = 0;
  logic [23:0] ln_word = '0;
  longint      ln_sum = 0, tare_ofs = 0;
  logic        ln_clk = 1'b0, ln_tout = 1'b0;

  reading_t    readings_due[$];
  int          errors = 0;
  int          cmds_run = 0, results_seen = 0;
  bit          no_idle = 1'b0;
  pattern_e    pattern = PAT_RANDOM;

  function automatic void start_conversions(int unsigned n);
    ln_total = n;
    ln_left  = n;
    ln_sum   = 0;
    ln_tout  = 1'b0;
    ln_phase = PH_WAIT;
    ln_ticks = 0;
    ln_clk   = 1'b0;
  endfunction

  function automatic reading_t step_line(logic [2:0] op, logic [7:0] cnt, logic dout);
    reading_t    r;
    logic        fin, sample_end;
    longint      avg, net, units, p;
    int unsigned half;
    r = '0;
    fin = 1'b0;
    sample_end = 1'b0;
    avg = 0;
    net = 0;
    units = 0;
    half = (c_half == 0) ? 1 : c_half;
    case (ln_phase)
      PH_IDLE: begin
        if (op == OP_READ || op == OP_TARE) begin
          ln_kind = op;
          start_conversions((cnt == 0) ? 1 : cnt);
        end else if (op == OP_PDOWN) begin
          ln_kind = op;
          ln_clk = 1'b1;
          ln_ticks = 0;
          ln_phase = PH_PDOWN;
        end else if (op == OP_PUP) begin
          ln_kind = op;
          ln_clk = 1'b0;
          ln_ticks = 0;
          ln_phase = PH_SETTLE;
        end
      end
      PH_WAIT: begin
        if (!dout) begin
          ln_phase = PH_HIGH;
          ln_clk = 1'b1;
          ln_ticks = 1;
          ln_bit = 0;
          ln_word = '0;
        end else if (ln_ticks >= c_timeout) begin
          ln_tout = 1'b1;
          ln_word = '0;
          sample_end = 1'b1;
        end else ln_ticks++;
      end
      PH_HIGH: begin
        if (ln_ticks >= half) begin
          if (ln_bit < 24) ln_word = {ln_word[22:0], dout};
          ln_bit++;
          ln_phase = PH_LOW;
          ln_clk = 1'b0;
          ln_ticks = 1;
        end else ln_ticks++;
      end
      PH_LOW: begin
        if (ln_ticks >= half) begin
          if (ln_bit < 24 + c_gain) begin
            ln_phase = PH_HIGH;
            ln_clk = 1'b1;
            ln_ticks = 1;
          end else sample_end = 1'b1;
        end else ln_ticks++;
      end
      PH_PDOWN: begin
        if (ln_ticks >= c_pdown) begin
          ln_phase = PH_IDLE;
          fin = 1'b1;
        end else ln_ticks++;
      end
      PH_SETTLE: begin
        if (ln_ticks >= c_settle) start_conversions(1);
        else ln_ticks++;
      end
      default: ln_phase = PH_IDLE;
    endcase

    if (sample_end) begin
      ln_sum += longint'($signed(ln_word));
      if (ln_left > 0) ln_left--;
      ln_clk = 1'b0;
      ln_ticks = 0;
      if (ln_left > 0) begin
        ln_phase = PH_WAIT;
      end else begin
        ln_phase = PH_IDLE;
        fin = 1'b1;
        r.tout = ln_tout;
        avg = ln_sum / longint'(ln_total);  // truncates toward zero
        if (avg > 8388607) avg = 8388607;
        if (avg < -8388608) avg = -8388608;
        if (ln_kind == OP_READ) begin
          net = avg - tare_ofs;
          p = net * c_scale;
          units = p >>> 16;
          if (units > 64'sd549755813887) units = 64'sd549755813887;
          if (units < -64'sd549755813888) units = -64'sd549755813888;
        end else if (ln_kind == OP_TARE) begin
          tare_ofs = avg;
        end else avg = 0;
      end
    end
    r.sck   = ln_clk;
    r.busy  = (ln_phase != PH_IDLE);
    r.done  = fin;
    r.avg   = avg[23:0];
    r.net   = net[24:0];
    r.units = units[39:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // result side: random stall bursts, none in the last part
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (no_idle) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
      stall_left = $urandom_range(1, 13);
    end
  end

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (readings_due.size() == 0) begin
        $display("unexpected result item at %0t", $time);
        errors++;
      end else begin
        want = readings_due.pop_front();
        if (sck_level_o !== want.sck) report_mismatch("sck_level", sck_level_o, want.sck);
        if (busy_res_o !== want.busy) report_mismatch("busy", busy_res_o, want.busy);
        if (done_res_o !== want.done) report_mismatch("done", done_res_o, want.done);
        if (raw_average_o !== want.avg) report_mismatch("raw_average", raw_average_o, want.avg);
        if (net_counts_o !== want.net) report_mismatch("net_counts", net_counts_o, want.net);
        if (units_o !== want.units) report_mismatch("units", units_o, want.units);
        if (timed_out_o !== want.tout) report_mismatch("timed_out", timed_out_o, want.tout);
      end
    end
  end

  task automatic send_tick(logic [2:0] op, logic [7:0] cnt, logic dout);
    int gap;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    operation_i = op;
    sample_count_i = cnt;
    dout_level_i = dout;
    do @(posedge clk_i); while (in_stall_o);
    if (ln_phase == PH_IDLE && op inside {OP_READ, OP_TARE, OP_PDOWN, OP_PUP}) cmds_run++;
    readings_due.push_back(step_line(op, cnt, dout));
  endtask

  // data pin level for the next tick, from the predicted line state
  function automatic logic pin_level();
    case (ln_phase)
      PH_WAIT: begin
        if (pattern == PAT_NEVER_READY) return 1'b1;
        return ($urandom_range(0, 2) != 0);
      end
      PH_HIGH: begin
        case (pattern)
          PAT_ONES:  return 1'b1;
          PAT_ZEROS: return 1'b0;
          PAT_MIN:   return (ln_bit == 0);
          PAT_MAX:   return (ln_bit != 0);
          default:   return 1'($urandom_range(0, 1));
        endcase
      end
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // a busy-time op field is ignored, so fill it with anything
  task automatic tick_until_idle();
    while (ln_phase != PH_IDLE)
      send_tick(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), pin_level());
  endtask

  task automatic run_cmd(logic [2:0] op, logic [7:0] cnt, pattern_e pat);
    pattern = pat;
    send_tick(op, cnt, pin_level());
    tick_until_idle();
    pattern = PAT_RANDOM;
  endtask

  // the sender stops and waits for every outstanding result before a write
  task automatic write_reg(cfg_e idx, logic [31:0] val);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (readings_due.size() == 0);
    repeat (40) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_GAIN:    c_gain = val[1:0];
      CFG_HALF:    c_half = val[7:0];
      CFG_TIMEOUT: c_timeout = val;
      CFG_SETTLE:  c_settle = val;
      CFG_PDOWN:   c_pdown = val[15:0];
      CFG_SCALE:   c_scale = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic setup(int g, int h, int unsigned to, int unsigned st, int pd,
                       logic [31:0] sc);
    write_reg(CFG_GAIN, g);
    write_reg(CFG_HALF, h);
    write_reg(CFG_TIMEOUT, to);
    write_reg(CFG_SETTLE, st);
    write_reg(CFG_PDOWN, pd);
    write_reg(CFG_SCALE, sc);
  endtask

  // random ticks; ignored idle ticks are not counted
  task automatic run_random(int n);
    int        done_items;
    logic [2:0] op;
    logic [7:0] cnt;
    done_items = 0;
    while (done_items < n) begin
      if (ln_phase == PH_IDLE) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: op = OP_READ;
          4, 5:       op = OP_TARE;
          6:          op = OP_PDOWN;
          7:          op = OP_PUP;
          8:          op = OP_NONE;
          default:    op = 3'($urandom_range(5, 7));
        endcase
        cnt = 8'($urandom_range(0, 3));
        pattern = pattern_e'($urandom_range(0, 9) < 7 ? PAT_RANDOM
                                                      : $urandom_range(1, 5));
      end else begin
        op = 3'($urandom_range(0, 7));
        cnt = 8'($urandom_range(0, 255));
      end
      if (ln_phase != PH_IDLE || op inside {OP_READ, OP_TARE, OP_PDOWN, OP_PUP})
        done_items++;
      send_tick(op, cnt, pin_level());
    end
    tick_until_idle();
    pattern = PAT_RANDOM;
  endtask

  // only the clock half is shortened; gain, timeout and scale keep reset values
  task automatic test_defaults();
    write_reg(CFG_HALF, 32'd1);
    run_cmd(OP_READ, 1, PAT_RANDOM);
  endtask

  task automatic test_directed();
    setup(0, 1, 0, 0, 0, 32'h7FFF_FFFF);
    run_cmd(OP_READ, 0, PAT_MAX);
    run_cmd(OP_TARE, 1, PAT_MAX);
    run_cmd(OP_READ, 1, PAT_MIN);       // most negative net against max scale
    run_cmd(OP_READ, 1, PAT_NEVER_READY);
    run_cmd(OP_TARE, 2, PAT_NEVER_READY);
    run_cmd(OP_PDOWN, 0, PAT_RANDOM);
    run_cmd(OP_PUP, 0, PAT_NEVER_READY);
    run_cmd(OP_NONE, 0, PAT_RANDOM);
    run_cmd(3'd5, 1, PAT_RANDOM);
    run_cmd(3'd6, 1, PAT_RANDOM);
    run_cmd(3'd7, 255, PAT_RANDOM);
    write_reg(CFG_SCALE, 32'h8000_0000);
    run_cmd(OP_TARE, 1, PAT_MIN);
    run_cmd(OP_READ, 1, PAT_MAX);       // most positive net against min scale
  endtask

  task automatic test_register_extremes();
    setup(3, 0, 32'hFFFF_FFFF, 3, 65535, 32'h0100_0000);
    run_cmd(OP_READ, 1, PAT_RANDOM);
    setup(2, 255, 7, 32'hFFFF_FFFF, 3, 32'hFFFF_F000);
    run_cmd(OP_READ, 2, PAT_NEVER_READY);
    run_cmd(OP_PDOWN, 0, PAT_RANDOM);
  endtask

  task automatic test_random_mix();
    setup(1, 1, 5, 4, 6, 32'h0001_8000);
    run_random(50);
    setup(0, 1, 1, 9, 2, $urandom);
    run_random(50);
  endtask

  task automatic test_no_idle();
    setup(2, 1, 3, 2, 4, $urandom);
    no_idle = 1'b1;
    run_random(40);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_defaults();
    test_directed();
    test_register_extremes();
    test_random_mix();
    test_no_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (readings_due.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("ran %0d commands over %0d ticks: read, tare, power down/up,",
             cmds_run, results_seen);
    $display("timeouts, sign extremes and register extremes, with random stalls");
    if (errors == 0 && readings_due.size() == 0) begin
      $display("tb_load_cell_adc_serial_reader: PASS");
    end else begin
      $display("tb_load_cell_adc_serial_reader: FAIL");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("timeout with %0d results outstanding", readings_due.size());
    $display("tb_load_cell_adc_serial_reader: FAIL");
    $finish;
  end

endmodule

@@ load_cell_adc_serial_reader.f @@
hw/rtl/lcr_pkg.sv
hw/rtl/lcr_ctrl.sv
hw/rtl/lcr_dp.sv
hw/rtl/load_cell_adc_serial_reader.sv
hw/rtl/lcr_checker.sv
tb/tb_load_cell_adc_serial_reader.sv
